// ===== rtl/cwb_pkg.sv =====
// Shared types and constants of the write/erase coalescing buffer.
package cwb_pkg;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_ERASE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_FLUSH = 2'd3;

   localparam logic [1:0] KIND_DONE  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_ERASE = 2'd2;
   localparam logic [1:0] KIND_READ  = 2'd3;

   localparam logic [3:0] CSR_BUFFER_LIMIT = 4'd0;
   localparam logic [3:0] CSR_ERASE_CHUNK  = 4'd1;

   localparam logic [3:0] LIMIT_RESET = 4'd8;
   localparam logic [4:0] CHUNK_RESET = 5'd10;

   // result slots per transaction; one more would be the result cap itself
   localparam int         RESULT_DEPTH = 64;
   localparam logic [5:0] RESULT_MAX   = 6'd63;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_READ_INIT,
      CMD_READ_STEP,
      CMD_FLUSH_INIT,
      CMD_FLUSH_STEP,
      CMD_APPEND,
      CMD_FILL_NEW,
      CMD_FILL_STEP,
      CMD_COMPACT_STEP,
      CMD_SCAN_STEP,
      CMD_RUN_STEP,
      CMD_INSERT,
      CMD_EMIT_DONE,
      CMD_DRAIN_NEXT
   } dp_cmd_type;

   typedef struct packed {
      logic       full;
      logic       in_range;
      logic       read_end;
      logic       flush_end;
      logic       fill_end;
      logic       compact_end;
      logic       compact_fold;
      logic       scan_end;
      logic       scan_hit;
      logic       run_end;
      logic       drain_last;
      logic [1:0] opcode;
   } dp_status_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [6:0]  blk;
      logic [31:0] data;
      logic [7:0]  len;
      logic        hit;
   } result_type;

endpackage

// ===== rtl/cwb_req_if.sv =====
// Request channel interface.
interface cwb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [6:0]  block;
   logic [31:0] data;
   logic [7:0]  length;
   modport source (output valid, opcode, block, data, length, input ready);
   modport sink   (input valid, opcode, block, data, length, output ready);
endinterface

// ===== rtl/cwb_rsp_if.sv =====
// Response channel interface.
interface cwb_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [6:0]  out_block;
   logic [31:0] out_data;
   logic [7:0]  out_length;
   logic        hit;
   logic [3:0]  occupancy;
   logic        last;
   modport source (output valid, kind, out_block, out_data, out_length, hit, occupancy,
                   last, input ready);
   modport sink   (input valid, kind, out_block, out_data, out_length, hit, occupancy,
                   last, output ready);
endinterface

// ===== rtl/cwb_csr_if.sv =====
// Configuration write channel interface.
interface cwb_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] index;
   logic [7:0] wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// ===== rtl/cwb_datapath.sv =====
// Datapath: command buffer, block map, cursors and result queue.
module cwb_datapath #(
   parameter int BLOCK_COUNT  = 128,
   parameter int BUFFER_DEPTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cwb_pkg::dp_cmd_type   cmd,
   output cwb_pkg::dp_status_type status,
   input  logic [1:0]            req_opcode,
   input  logic [6:0]            req_block,
   input  logic [31:0]           req_data,
   input  logic [7:0]            req_length,
   input  logic                  csr_write,
   input  logic [3:0]            csr_index,
   input  logic [7:0]            csr_wdata,
   output logic [1:0]            rsp_kind,
   output logic [6:0]            rsp_out_block,
   output logic [31:0]           rsp_out_data,
   output logic [7:0]            rsp_out_length,
   output logic                  rsp_hit,
   output logic [3:0]            rsp_occupancy,
   output logic                  rsp_last
);
   localparam int MAP = (BLOCK_COUNT < 128) ? BLOCK_COUNT : 128;
   localparam int MW  = $clog2(MAP);
   localparam int CW  = $clog2(BUFFER_DEPTH + 1);
   localparam int IW  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam logic [7:0] MAP8 = 8'(MAP);
   localparam logic [8:0] MAP9 = 9'(MAP);
   localparam logic [4:0] DEPTH5 = 5'(BUFFER_DEPTH);

   logic        ent_erase_ff [BUFFER_DEPTH];
   logic [6:0]  ent_blk_ff   [BUFFER_DEPTH];
   logic [31:0] ent_pay_ff   [BUFFER_DEPTH];
   logic [CW-1:0]  count_ff;
   logic [MAP-1:0] map_ff;

   logic [1:0]  op_ff;
   logic [6:0]  blk_ff;
   logic [31:0] data_ff;
   logic [7:0]  len_ff;
   logic [8:0]  rend_ff;
   logic [CW-1:0] ci_ff;
   logic [CW-1:0] k_ff;
   logic [7:0]  fb_ff;
   logic [8:0]  fe_ff;
   logic [7:0]  bcur_ff;
   logic [6:0]  start_ff;
   logic [4:0]  rl_ff;
   logic [5:0]  wcnt_ff;
   logic [5:0]  rd_ff;
   logic [3:0]  limit_ff;
   logic [4:0]  chunk_ff;

   cwb_pkg::result_type res_mem [cwb_pkg::RESULT_DEPTH];
   cwb_pkg::result_type q_ff;

   logic [IW-1:0] ci_idx, prev_idx;
   logic          cur_e, prev_e;
   logic [6:0]    cur_b, prev_b;
   logic [31:0]   cur_p, prev_p;
   logic          ci_lt, read_zero, read_match;
   logic [4:0]    lim_eff, chunk_eff;
   logic [7:0]    maxlen, lenc;
   logic          wr_covered;
   logic [8:0]    fold_sum, fold_end;
   logic          map_bit, b_lt, run_go, fill_end;
   logic          emit_en;
   cwb_pkg::result_type emit_rec;

   assign ci_idx   = ci_ff[IW-1:0];
   assign prev_idx = IW'(ci_ff - CW'(1));
   assign cur_e    = ent_erase_ff[ci_idx];
   assign cur_b    = ent_blk_ff[ci_idx];
   assign cur_p    = ent_pay_ff[ci_idx];
   assign prev_e   = ent_erase_ff[prev_idx];
   assign prev_b   = ent_blk_ff[prev_idx];
   assign prev_p   = ent_pay_ff[prev_idx];
   assign ci_lt    = ci_ff < count_ff;

   // newest-first lookup looks at entry ci-1
   assign read_zero  = (ci_ff == '0);
   assign read_match = !read_zero &&
      (prev_e ? ((blk_ff >= prev_b) &&
                 ({2'b00, blk_ff} < ({2'b00, prev_b} + {1'b0, prev_p[7:0]})))
              : (prev_b == blk_ff));

   always_comb begin
      lim_eff = {1'b0, limit_ff};
      if (lim_eff == 5'd0) lim_eff = 5'd1;
      if (lim_eff > DEPTH5) lim_eff = DEPTH5;
   end
   assign chunk_eff = (chunk_ff == 5'd0) ? 5'd1 : chunk_ff;

   // erase length clipped to the end of the map
   assign maxlen = MAP8 - {1'b0, req_block};
   assign lenc   = (req_length > maxlen) ? maxlen : req_length;

   assign wr_covered = (cur_b >= blk_ff) && ({2'b00, cur_b} < rend_ff);
   assign fold_sum   = {2'b00, cur_b} + {1'b0, cur_p[7:0]};
   assign fold_end   = (fold_sum > MAP9) ? MAP9 : fold_sum;
   assign fill_end   = ({1'b0, fb_ff} >= fe_ff);
   assign b_lt       = bcur_ff < MAP8;
   assign map_bit    = map_ff[bcur_ff[MW-1:0]];
   assign run_go     = b_lt && map_bit && (rl_ff < chunk_eff);

   always_comb begin
      status.full         = (5'(count_ff) >= lim_eff);
      status.in_range     = ({1'b0, blk_ff} < MAP8);
      status.read_end     = read_zero || read_match;
      status.flush_end    = !ci_lt;
      status.fill_end     = fill_end;
      status.compact_end  = !ci_lt;
      status.compact_fold = ci_lt && cur_e && (op_ff == cwb_pkg::OP_ERASE);
      status.scan_end     = !b_lt;
      status.scan_hit     = b_lt && map_bit;
      status.run_end      = !run_go;
      status.drain_last   = (rd_ff == (wcnt_ff - 6'd1));
      status.opcode       = op_ff;
   end

   always_comb begin
      emit_en  = 1'b0;
      emit_rec = '0;
      unique case (cmd)
         cwb_pkg::CMD_READ_STEP: begin
            if (read_zero || read_match) begin
               emit_en       = 1'b1;
               emit_rec.kind = cwb_pkg::KIND_READ;
               emit_rec.blk  = blk_ff;
               emit_rec.hit  = read_match;
               emit_rec.data = (read_match && !prev_e) ? prev_p : 32'd0;
            end
         end
         cwb_pkg::CMD_FLUSH_STEP: begin
            if (ci_lt) begin
               emit_rec.blk = cur_b;
               if (cur_e) begin
                  emit_en       = (cur_p != 32'd0);
                  emit_rec.kind = cwb_pkg::KIND_ERASE;
                  emit_rec.len  = cur_p[7:0];
               end else begin
                  emit_en       = 1'b1;
                  emit_rec.kind = cwb_pkg::KIND_WRITE;
                  emit_rec.data = cur_p;
               end
            end
         end
         cwb_pkg::CMD_EMIT_DONE: begin
            emit_en       = 1'b1;
            emit_rec.kind = cwb_pkg::KIND_DONE;
         end
         default: ;
      endcase
   end

   // result queue
   always_ff @(posedge clock) begin
      if (emit_en && (wcnt_ff < cwb_pkg::RESULT_MAX)) res_mem[wcnt_ff] <= emit_rec;
      q_ff <= res_mem[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         map_ff   <= '0;
         wcnt_ff  <= '0;
         rd_ff    <= '0;
         limit_ff <= cwb_pkg::LIMIT_RESET;
         chunk_ff <= cwb_pkg::CHUNK_RESET;
      end else begin
         if (csr_write) begin
            if (csr_index == cwb_pkg::CSR_BUFFER_LIMIT) limit_ff <= csr_wdata[3:0];
            else if (csr_index == cwb_pkg::CSR_ERASE_CHUNK) chunk_ff <= csr_wdata[4:0];
         end
         if (emit_en && (wcnt_ff < cwb_pkg::RESULT_MAX)) wcnt_ff <= wcnt_ff + 6'd1;
         unique case (cmd)
            cwb_pkg::CMD_LOAD: begin
               op_ff   <= req_opcode;
               blk_ff  <= req_block;
               data_ff <= req_data;
               len_ff  <= lenc;
               rend_ff <= {2'b00, req_block} +
                          ((req_opcode == cwb_pkg::OP_ERASE) ? {1'b0, lenc} : 9'd1);
               ci_ff   <= '0;
               k_ff    <= '0;
               bcur_ff <= '0;
               wcnt_ff <= '0;
               rd_ff   <= '0;
               map_ff  <= '0;
            end
            cwb_pkg::CMD_READ_INIT: ci_ff <= count_ff;
            cwb_pkg::CMD_READ_STEP: begin
               if (!(read_zero || read_match)) ci_ff <= ci_ff - CW'(1);
            end
            cwb_pkg::CMD_FLUSH_INIT: ci_ff <= '0;
            cwb_pkg::CMD_FLUSH_STEP: begin
               if (ci_lt) ci_ff <= ci_ff + CW'(1);
               else count_ff <= '0;
            end
            cwb_pkg::CMD_APPEND: begin
               ent_erase_ff[count_ff[IW-1:0]] <= (op_ff == cwb_pkg::OP_ERASE);
               ent_blk_ff[count_ff[IW-1:0]]   <= blk_ff;
               ent_pay_ff[count_ff[IW-1:0]]   <=
                  (op_ff == cwb_pkg::OP_ERASE) ? {24'd0, len_ff} : data_ff;
               count_ff <= count_ff + CW'(1);
            end
            cwb_pkg::CMD_FILL_NEW: begin
               fb_ff <= {1'b0, blk_ff};
               fe_ff <= rend_ff;
            end
            cwb_pkg::CMD_FILL_STEP: begin
               if (!fill_end) begin
                  map_ff[fb_ff[MW-1:0]] <= 1'b1;
                  fb_ff <= fb_ff + 8'd1;
               end
            end
            cwb_pkg::CMD_COMPACT_STEP: begin
               if (ci_lt) begin
                  ci_ff <= ci_ff + CW'(1);
                  if (cur_e && (op_ff == cwb_pkg::OP_ERASE)) begin
                     fb_ff <= {1'b0, cur_b};
                     fe_ff <= fold_end;
                  end else if (cur_e || !wr_covered) begin
                     ent_erase_ff[k_ff[IW-1:0]] <= cur_e;
                     ent_blk_ff[k_ff[IW-1:0]]   <= cur_b;
                     ent_pay_ff[k_ff[IW-1:0]]   <= cur_p;
                     k_ff <= k_ff + CW'(1);
                  end
               end else begin
                  count_ff <= k_ff;
               end
            end
            cwb_pkg::CMD_SCAN_STEP: begin
               if (b_lt) begin
                  if (map_bit) begin
                     start_ff <= bcur_ff[6:0];
                     rl_ff    <= '0;
                  end else begin
                     bcur_ff <= bcur_ff + 8'd1;
                  end
               end
            end
            cwb_pkg::CMD_RUN_STEP: begin
               if (run_go) begin
                  bcur_ff <= bcur_ff + 8'd1;
                  rl_ff   <= rl_ff + 5'd1;
               end
            end
            cwb_pkg::CMD_INSERT: begin
               for (int j = BUFFER_DEPTH - 1; j > 0; j--) begin
                  ent_erase_ff[j] <= ent_erase_ff[j-1];
                  ent_blk_ff[j]   <= ent_blk_ff[j-1];
                  ent_pay_ff[j]   <= ent_pay_ff[j-1];
               end
               ent_erase_ff[0] <= 1'b1;
               ent_blk_ff[0]   <= start_ff;
               ent_pay_ff[0]   <= {27'd0, rl_ff};
               count_ff <= count_ff + CW'(1);
            end
            cwb_pkg::CMD_DRAIN_NEXT: rd_ff <= rd_ff + 6'd1;
            default: ;
         endcase
      end
   end

   assign rsp_kind       = q_ff.kind;
   assign rsp_out_block  = q_ff.blk;
   assign rsp_out_data   = q_ff.data;
   assign rsp_out_length = q_ff.len;
   assign rsp_hit        = q_ff.hit;
   assign rsp_occupancy  = 4'(count_ff);
   assign rsp_last       = status.drain_last;
endmodule

// ===== rtl/cwb_controller.sv =====
// Controller: sequences one transaction through the datapath.
module cwb_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  cwb_pkg::dp_status_type status,
   output cwb_pkg::dp_cmd_type    cmd
);
   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_READ, S_FLUSH, S_APPEND, S_FILL, S_COMPACT,
      S_SCAN, S_RUN, S_INSERT, S_DONE, S_DRAIN_RD, S_SHOW
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      cmd      = cwb_pkg::CMD_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd      = cwb_pkg::CMD_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            priority if (status.opcode == cwb_pkg::OP_READ) begin
               cmd      = cwb_pkg::CMD_READ_INIT;
               state_in = S_READ;
            end else if (status.opcode == cwb_pkg::OP_FLUSH) begin
               cmd      = cwb_pkg::CMD_FLUSH_INIT;
               ret_in   = S_DONE;
               state_in = S_FLUSH;
            end else if (!status.in_range) begin
               state_in = S_DONE;
            end else if (status.full) begin
               cmd      = cwb_pkg::CMD_FLUSH_INIT;
               ret_in   = S_APPEND;
               state_in = S_FLUSH;
            end else if (status.opcode == cwb_pkg::OP_WRITE) begin
               state_in = S_COMPACT;
            end else begin
               cmd      = cwb_pkg::CMD_FILL_NEW;
               state_in = S_FILL;
            end
         end
         S_READ: begin
            cmd = cwb_pkg::CMD_READ_STEP;
            if (status.read_end) state_in = S_DRAIN_RD;
         end
         S_FLUSH: begin
            cmd = cwb_pkg::CMD_FLUSH_STEP;
            if (status.flush_end) state_in = ret_ff;
         end
         S_APPEND: begin
            cmd      = cwb_pkg::CMD_APPEND;
            state_in = S_DONE;
         end
         S_FILL: begin
            cmd = cwb_pkg::CMD_FILL_STEP;
            if (status.fill_end) state_in = S_COMPACT;
         end
         S_COMPACT: begin
            cmd = cwb_pkg::CMD_COMPACT_STEP;
            priority if (status.compact_end)
               state_in = (status.opcode == cwb_pkg::OP_WRITE) ? S_APPEND : S_SCAN;
            else if (status.compact_fold)
               state_in = S_FILL;
         end
         S_SCAN: begin
            cmd = cwb_pkg::CMD_SCAN_STEP;
            priority if (status.scan_end) state_in = S_DONE;
            else if (status.scan_hit) state_in = S_RUN;
         end
         S_RUN: begin
            cmd = cwb_pkg::CMD_RUN_STEP;
            if (status.run_end) begin
               if (status.full) begin
                  state_in = S_FLUSH;
                  ret_in   = S_INSERT;
               end else begin
                  state_in = S_INSERT;
               end
            end
         end
         S_INSERT: begin
            cmd      = cwb_pkg::CMD_INSERT;
            state_in = S_SCAN;
         end
         S_DONE: begin
            cmd      = cwb_pkg::CMD_EMIT_DONE;
            state_in = S_DRAIN_RD;
         end
         S_DRAIN_RD: state_in = S_SHOW;
         S_SHOW: begin
            if (rsp_ready) begin
               if (status.drain_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd      = cwb_pkg::CMD_DRAIN_NEXT;
                  state_in = S_DRAIN_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      // a flush out of RUN starts its cursor at entry zero
      if (state_ff == S_RUN && status.run_end && status.full) cmd = cwb_pkg::CMD_FLUSH_INIT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_DONE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_SHOW);
endmodule

// ===== rtl/ssd_write_erase_coalescing_buffer.sv =====
// Top level of the SSD write/erase coalescing command buffer.
// A read answer shows after a newest-first walk over the buffered entries up to the first match;
// a write shows its done after a pass over the buffered entries; an erase adds the map fill (new and
// buffered erase lengths, one block per cycle), one walk of the map and any buffer flushes.
// One transaction at a time: the next is accepted in the cycle after its last result;
// each result passes a queue read and a show state, plus stalls. Reset: buffer empty, map clear.
module ssd_write_erase_coalescing_buffer #(
   parameter int BLOCK_COUNT  = 128,
   parameter int BUFFER_DEPTH = 8
) (
   input logic        clock,
   input logic        reset,
   cwb_req_if.sink    req_port,
   cwb_rsp_if.source  rsp_port,
   cwb_csr_if.sink    csr_port
);
   cwb_pkg::dp_cmd_type    cmd;
   cwb_pkg::dp_status_type status;

   // config writes are always taken; the user must send them only while idle, which is not enforced here
   assign csr_port.ready = 1'b1;

   // sequencer: accepts a transaction, steps the datapath, drains the results
   cwb_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // buffer, block map and result queue
   cwb_datapath #(
      .BLOCK_COUNT  (BLOCK_COUNT),
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_opcode     (req_port.opcode),
      .req_block      (req_port.block),
      .req_data       (req_port.data),
      .req_length     (req_port.length),
      .csr_write      (csr_port.valid),
      .csr_index      (csr_port.index),
      .csr_wdata      (csr_port.wdata),
      .rsp_kind       (rsp_port.kind),
      .rsp_out_block  (rsp_port.out_block),
      .rsp_out_data   (rsp_port.out_data),
      .rsp_out_length (rsp_port.out_length),
      .rsp_hit        (rsp_port.hit),
      .rsp_occupancy  (rsp_port.occupancy),
      .rsp_last       (rsp_port.last)
   );

   // no new transaction while results are pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid |-> !req_port.ready)
      else $error("request accepted while results pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_port.valid && req_port.ready) |=> !req_port.ready)
      else $error("ready did not drop after accept");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && rsp_port.ready && rsp_port.last) |=> req_port.ready)
      else $error("not idle after last result");
endmodule

// ===== tb/sv/testbench.sv =====
// Testbench of the write/erase coalescing buffer: scoreboard with behavioral predictor.
`timescale 1ns / 100ps

module testbench;

   localparam int MAP_BLOCKS = 128;
   localparam int DEPTH      = 8;
   localparam int CMD_CAP    = 63;   // device commands kept per transaction

   typedef struct {
      logic [1:0]  kind;
      logic [6:0]  blk;
      logic [31:0] data;
      logic [7:0]  len;
      logic        hit;
      logic [3:0]  occ;
      logic        last;
   } rsp_item_type;

   // Scoreboard: keeps its own copy of the buffer and predicts every response.
   class cwb_scoreboard_type;
      bit           ent_erase[DEPTH];
      int           ent_blk[DEPTH];
      logic [31:0]  ent_pay[DEPTH];
      int           ent_cnt;
      bit           blk_map[MAP_BLOCKS];
      int           limit_reg;
      int           chunk_reg;
      rsp_item_type pending_rsp[$];
      rsp_item_type cur[$];
      int           errors;

      function new();
         ent_cnt   = 0;
         limit_reg = cwb_pkg::LIMIT_RESET;
         chunk_reg = cwb_pkg::CHUNK_RESET;
         errors    = 0;
         foreach (blk_map[i]) blk_map[i] = 0;
      endfunction

      function void set_reg(logic [3:0] idx, logic [7:0] val);
         if (idx == cwb_pkg::CSR_BUFFER_LIMIT) limit_reg = val & 15;
         else if (idx == cwb_pkg::CSR_ERASE_CHUNK) chunk_reg = val & 31;
      endfunction

      function int eff_limit();
         if (limit_reg < 1) return 1;
         if (limit_reg > DEPTH) return DEPTH;
         return limit_reg;
      endfunction

      function void add_cmd(logic [1:0] kind, int blk, logic [31:0] data, int len,
                            logic hit);
         rsp_item_type r;
         if (cur.size() >= CMD_CAP) return;
         r.kind = kind;
         r.blk  = blk[6:0];
         r.data = data;
         r.len  = len[7:0];
         r.hit  = hit;
         r.occ  = 0;
         r.last = 0;
         cur = {cur, r};
      endfunction

      function void drain_buffer();
         for (int i = 0; i < ent_cnt; i++) begin
            if (ent_erase[i]) begin
               if (ent_pay[i] != 0)
                  add_cmd(cwb_pkg::KIND_ERASE, ent_blk[i], 0, ent_pay[i], 0);
            end else begin
               add_cmd(cwb_pkg::KIND_WRITE, ent_blk[i], ent_pay[i], 0, 0);
            end
         end
         ent_cnt = 0;
      endfunction

      function void put(int pos, bit er, int blk, logic [31:0] pay);
         ent_erase[pos] = er;
         ent_blk[pos]   = blk & 127;
         ent_pay[pos]   = pay;
      endfunction

      function void append_entry(bit er, int blk, logic [31:0] pay);
         if (ent_cnt >= eff_limit()) drain_buffer();
         put(ent_cnt, er, blk, pay);
         ent_cnt++;
      endfunction

      function void push_front_erase(int blk, int len);
         if (ent_cnt >= eff_limit()) drain_buffer();
         for (int i = ent_cnt; i > 0; i--)
            put(i, ent_erase[i-1], ent_blk[i-1], ent_pay[i-1]);
         put(0, 1, blk, len);
         ent_cnt++;
      endfunction

      // drop buffered writes to marked blocks, keep order
      function void drop_writes();
         int k;
         k = 0;
         for (int i = 0; i < ent_cnt; i++) begin
            if (ent_erase[i] || !blk_map[ent_blk[i]]) begin
               put(k, ent_erase[i], ent_blk[i], ent_pay[i]);
               k++;
            end
         end
         ent_cnt = k;
      endfunction

      // move buffered erases into the map, keep the writes
      function void absorb_erases();
         int k;
         k = 0;
         for (int i = 0; i < ent_cnt; i++) begin
            if (ent_erase[i]) begin
               for (int b = ent_blk[i]; b < MAP_BLOCKS && b < ent_blk[i] + int'(ent_pay[i]); b++)
                  blk_map[b] = 1;
            end else begin
               put(k, 0, ent_blk[i], ent_pay[i]);
               k++;
            end
         end
         ent_cnt = k;
      endfunction

      function void emit_runs();
         int c, b, start;
         c = (chunk_reg != 0) ? chunk_reg : 1;
         b = 0;
         while (b < MAP_BLOCKS) begin
            if (!blk_map[b]) begin
               b++;
            end else begin
               start = b;
               while (b < MAP_BLOCKS && blk_map[b] && b - start < c) b++;
               push_front_erase(start, b - start);
            end
         end
      endfunction

      function void clear_map();
         foreach (blk_map[i]) blk_map[i] = 0;
      endfunction

      // accepted request: compute its responses
      function void note_request(logic [1:0] op, logic [6:0] blk, logic [31:0] data,
                                 logic [7:0] length);
         int          b, len, i;
         bit          hit;
         logic [31:0] val;
         b   = blk;
         len = length;
         cur.delete();
         if (op == cwb_pkg::OP_READ) begin
            hit = 0;
            val = 0;
            i   = ent_cnt;
            while (i > 0 && !hit) begin
               i--;
               if (ent_erase[i]) begin
                  if (b >= ent_blk[i] && b < ent_blk[i] + int'(ent_pay[i])) begin
                     hit = 1;
                     val = 0;
                  end
               end else if (ent_blk[i] == b) begin
                  hit = 1;
                  val = ent_pay[i];
               end
            end
            add_cmd(cwb_pkg::KIND_READ, b, val, 0, hit);
         end else begin
            if (op == cwb_pkg::OP_FLUSH) begin
               drain_buffer();
            end else begin
               if (op == cwb_pkg::OP_ERASE && len > MAP_BLOCKS - b) len = MAP_BLOCKS - b;
               if (ent_cnt >= eff_limit()) begin
                  // full: flush, then append as is
                  drain_buffer();
                  if (op == cwb_pkg::OP_WRITE) append_entry(0, b, data);
                  else append_entry(1, b, len);
               end else begin
                  clear_map();
                  if (op == cwb_pkg::OP_WRITE) begin
                     blk_map[b] = 1;
                     drop_writes();
                     append_entry(0, b, data);
                  end else begin
                     for (int k = b; k < b + len; k++) blk_map[k] = 1;
                     drop_writes();
                     absorb_erases();
                     emit_runs();
                  end
                  clear_map();
               end
            end
            add_cmd(cwb_pkg::KIND_DONE, 0, 0, 0, 0);
         end
         foreach (cur[k]) begin
            cur[k].occ  = ent_cnt[3:0];
            cur[k].last = (k == cur.size() - 1);
            pending_rsp = {pending_rsp, cur[k]};
         end
      endfunction

      function void check_response(rsp_item_type act);
         rsp_item_type exp;
         if (pending_rsp.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: unexpected response kind=%0d blk=%0d", $realtime,
                        act.kind, act.blk);
            return;
         end
         exp = pending_rsp.pop_front();
         if (exp.kind !== act.kind || exp.blk !== act.blk || exp.data !== act.data ||
             exp.len !== act.len || exp.hit !== act.hit || exp.occ !== act.occ ||
             exp.last !== act.last) begin
            errors++;
            if (errors <= 10)
               $display({"%0t: mismatch exp kind=%0d blk=%0d data=%h len=%0d hit=%0d",
                         " occ=%0d last=%0d / act kind=%0d blk=%0d data=%h len=%0d",
                         " hit=%0d occ=%0d last=%0d"}, $realtime,
                        exp.kind, exp.blk, exp.data, exp.len, exp.hit, exp.occ, exp.last,
                        act.kind, act.blk, act.data, act.len, act.hit, act.occ, act.last);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;

   cwb_req_if req_ch();
   cwb_rsp_if rsp_ch();
   cwb_csr_if csr_ch();

   ssd_write_erase_coalescing_buffer dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch),
      .csr_port (csr_ch)
   );

   cwb_scoreboard_type sb = new();

   int send_idle_pct = 35;   // sender gap chance, percent
   int recv_idle_pct = 60;   // receiver stall chance, percent

   always #5 clock = ~clock;

   // response side: random back-pressure, compare every accepted response
   always @(posedge clock) begin
      rsp_item_type act;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         act.kind = rsp_ch.kind;
         act.blk  = rsp_ch.out_block;
         act.data = rsp_ch.out_data;
         act.len  = rsp_ch.out_length;
         act.hit  = rsp_ch.hit;
         act.occ  = rsp_ch.occupancy;
         act.last = rsp_ch.last;
         sb.check_response(act);
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Send one request. Valid is left high after the transaction; the next call
   // (or hold_req) updates it in the same time step.
   task automatic send_req(logic [1:0] op, logic [6:0] blk, logic [31:0] data,
                           logic [7:0] len);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 0;
         @(posedge clock);
      end
      req_ch.valid  <= 1;
      req_ch.opcode <= op;
      req_ch.block  <= blk;
      req_ch.data   <= data;
      req_ch.length <= len;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(op, blk, data, len);
   endtask

   // stop sending and wait until every expected response has come
   task automatic hold_req();
      req_ch.valid <= 0;
      @(posedge clock);
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [3:0] idx, logic [7:0] val);
      hold_req();
      csr_ch.valid <= 1;
      csr_ch.index <= idx;
      csr_ch.wdata <= val;
      do @(posedge clock); while (!csr_ch.ready);
      sb.set_reg(idx, val);
      csr_ch.valid <= 0;
   endtask

   // narrow block window most of the time so reads and overlaps hit
   function automatic logic [6:0] pick_block();
      if ($urandom_range(3) != 0) return 7'($urandom_range(31));
      return 7'($urandom_range(127));
   endfunction

   function automatic logic [7:0] pick_length();
      if ($urandom_range(7) != 0) return 8'($urandom_range(12));
      return 8'($urandom_range(255));
   endfunction

   task automatic random_reqs(int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 40)
            send_req(cwb_pkg::OP_WRITE, pick_block(), $urandom, 8'($urandom));
         else if (r < 62)
            send_req(cwb_pkg::OP_ERASE, pick_block(), $urandom, pick_length());
         else if (r < 90)
            send_req(cwb_pkg::OP_READ, pick_block(), $urandom, 8'($urandom));
         else
            send_req(cwb_pkg::OP_FLUSH, 7'($urandom), $urandom, 8'($urandom));
      end
   endtask

   initial begin
      req_ch.valid  <= 0;
      req_ch.opcode <= cwb_pkg::OP_WRITE;
      req_ch.block  <= 0;
      req_ch.data   <= 0;
      req_ch.length <= 0;
      csr_ch.valid  <= 0;
      csr_ch.index  <= cwb_pkg::CSR_BUFFER_LIMIT;
      csr_ch.wdata  <= 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: field extremes, all opcodes, clipping and empty erases
      send_req(cwb_pkg::OP_READ,  7'd0,   32'h0,        8'd0);
      send_req(cwb_pkg::OP_WRITE, 7'd0,   32'hFFFFFFFF, 8'd255);
      send_req(cwb_pkg::OP_WRITE, 7'd127, 32'h0,        8'd0);
      send_req(cwb_pkg::OP_READ,  7'd127, 32'hFFFFFFFF, 8'd255);
      send_req(cwb_pkg::OP_ERASE, 7'd120, 32'h0,        8'd255);   // clipped at map end
      send_req(cwb_pkg::OP_READ,  7'd127, 32'h0,        8'd0);
      send_req(cwb_pkg::OP_ERASE, 7'd5,   32'hFFFFFFFF, 8'd0);     // empty, re-merge
      send_req(cwb_pkg::OP_WRITE, 7'd3,   32'h12345678, 8'd0);
      send_req(cwb_pkg::OP_ERASE, 7'd0,   32'h0,        8'd128);   // whole map
      send_req(cwb_pkg::OP_READ,  7'd3,   32'h0,        8'd0);
      send_req(cwb_pkg::OP_FLUSH, 7'd127, 32'hFFFFFFFF, 8'd255);
      send_req(cwb_pkg::OP_READ,  7'd64,  32'h0,        8'd0);
      for (int i = 0; i < 8; i++) send_req(cwb_pkg::OP_WRITE, 7'(i * 3), $urandom, 8'd0);
      send_req(cwb_pkg::OP_ERASE, 7'd40,  32'h0,        8'd0);     // full path, count zero
      send_req(cwb_pkg::OP_READ,  7'd40,  32'h0,        8'd0);
      send_req(cwb_pkg::OP_FLUSH, 7'd0,   32'h0,        8'd0);

      write_csr(cwb_pkg::CSR_BUFFER_LIMIT, 8'd1);
      write_csr(cwb_pkg::CSR_ERASE_CHUNK,  8'd1);
      random_reqs(20);
      send_req(cwb_pkg::OP_ERASE, 7'd0, 32'h0, 8'd128);   // many single-block chunks
      hold_req();                                          // sender waits for drain

      // sender and receiver swap idling
      send_idle_pct = 60;
      recv_idle_pct = 35;
      write_csr(cwb_pkg::CSR_BUFFER_LIMIT, 8'd15);
      write_csr(cwb_pkg::CSR_ERASE_CHUNK,  8'd31);
      random_reqs(40);

      // no idling, zero settings act as one
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(cwb_pkg::CSR_BUFFER_LIMIT, 8'd0);
      write_csr(cwb_pkg::CSR_ERASE_CHUNK,  8'd0);
      random_reqs(20);
      write_csr(cwb_pkg::CSR_BUFFER_LIMIT, 8'd8);
      write_csr(cwb_pkg::CSR_ERASE_CHUNK,  8'd16);
      random_reqs(26);

      hold_req();
      repeat (50) @(posedge clock);
      if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // timeout
   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end

endmodule
